// ----- design/kalman_angle_bias_filter_top_macros.svh -----
// Assertion macros shared by the Kalman filter block.
// Each macro takes a label, an antecedent, a consequent and a message.
`ifndef KALMAN_ANGLE_BIAS_FILTER_TOP_MACROS_SVH
`define KALMAN_ANGLE_BIAS_FILTER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define KABF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`define KABF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define KABF_ASSERT_IMP(lbl, ante, cons, msg)
`define KABF_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ----- design/kabf_pkg.sv -----
package kabf_pkg;

	// Field and datapath widths.
	localparam int DATA_W      = 32;
	localparam int MEAS_W      = 25;
	localparam int DT_W        = 17;
	localparam int NOISE_W     = 31;
	localparam int CFG_DATA_W  = 32;
	localparam int CFG_IDX_W   = 2;
	localparam int MUL_MW      = 40;
	localparam int MUL_BW      = 33;
	localparam int MUL_PW      = MUL_MW + 1 + MUL_BW;
	localparam int DIV_NW      = 32;
	localparam int DIV_SW      = 34;
	localparam int DIV_DW      = 64;
	localparam int WIDE_W      = 80;

	// Default fraction bits.
	localparam int ANGLE_FRAC_BITS_DEF = 16;
	localparam int COV_FRAC_BITS_DEF   = 30;

	// Register reset values.
	localparam logic [DT_W-1:0]    DT_RST = 17'd655;
	localparam logic [NOISE_W-1:0] QA_RST = 31'd1073742;
	localparam logic [NOISE_W-1:0] QB_RST = 31'd3221225;
	localparam logic [NOISE_W-1:0] R_RST  = 31'd32212255;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_Q_ANGLE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_Q_BIAS    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_R_MEAS    = 2'd3;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_ISSUE,
		ST_WAIT,
		ST_DONE
	} state_t;

	// Arithmetic steps of one update, in order.
	typedef enum logic [3:0] {
		OP_DT_RATE,
		OP_DT_P11,
		OP_DT_B,
		OP_DT_QB,
		OP_DIV_K0,
		OP_DIV_K1,
		OP_K0_Y,
		OP_K1_Y,
		OP_K0_N00,
		OP_K0_N01,
		OP_K1_N00,
		OP_K1_N01
	} op_t;

	// Phases of the serial arithmetic units.
	typedef enum logic [1:0] {
		PH_IDLE,
		PH_RUN,
		PH_FIX,
		PH_RND
	} phase_t;

	typedef struct packed {
		logic                     start;
		logic                     cov;
		logic signed [MUL_MW-1:0] m;
		logic signed [MUL_BW-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic                     start;
		logic signed [DIV_NW-1:0] num;
		logic signed [DIV_SW-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

	// Saturate a wide signed value to 32 bits.
	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] x);
		logic signed [DATA_W-1:0] r;
		if (x > 80'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (x < -80'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = x[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage

// ----- design/kabf_mul.sv -----
module kabf_mul import kabf_pkg::*; #(
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
	parameter int COV_FRAC_BITS   = COV_FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  mul_req_t                 req,
	output unit_sts_t                sts,
	output logic signed [MUL_PW-1:0] res
);

	localparam int CW = $clog2(MUL_BW + 1);

	phase_t                   phase_q, phase_nx;
	logic signed [MUL_MW:0]   acc_q;
	logic [MUL_BW-1:0]        lo_q;
	logic signed [MUL_MW-1:0] m_q;
	logic                     neg_q;
	logic                     cov_q;
	logic [CW-1:0]            cnt_q;
	logic signed [MUL_PW-1:0] prod_q;
	logic signed [MUL_PW-1:0] res_q;
	logic                     done_q;
	logic signed [MUL_MW+1:0] sum;
	logic signed [MUL_PW-1:0] half;
	logic signed [MUL_PW-1:0] raw;

	// One multiplier bit per cycle: add the multiplicand, then shift right.
	assign sum  = lo_q[0] ? ((MUL_MW+2)'(acc_q) + (MUL_MW+2)'(m_q)) : (MUL_MW+2)'(acc_q);
	assign raw  = {acc_q, lo_q};
	assign half = cov_q ? (MUL_PW'(1) <<< (COV_FRAC_BITS - 1))
		: (MUL_PW'(1) <<< (ANGLE_FRAC_BITS - 1));

	// Phase sequencing.
	always_comb begin
		phase_nx = phase_q;
		case (phase_q)
			PH_IDLE: if (req.start) phase_nx = PH_RUN;
			PH_RUN:  if (cnt_q == CW'(MUL_BW - 1)) phase_nx = PH_FIX;
			PH_FIX:  phase_nx = PH_RND;
			PH_RND:  phase_nx = PH_IDLE;
			default: phase_nx = PH_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			done_q  <= 1'b0;
		end else begin
			phase_q <= phase_nx;
			done_q  <= (phase_q == PH_RND);
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (phase_q)
			PH_IDLE: begin
				if (req.start) begin
					m_q   <= req.m;
					cov_q <= req.cov;
					neg_q <= req.b[MUL_BW-1];
					lo_q  <= req.b[MUL_BW-1] ? MUL_BW'(-req.b) : MUL_BW'(req.b);
					acc_q <= '0;
					cnt_q <= '0;
				end
			end
			PH_RUN: begin
				acc_q <= sum[MUL_MW+1:1];
				lo_q  <= {sum[0], lo_q[MUL_BW-1:1]};
				cnt_q <= cnt_q + CW'(1);
			end
			PH_FIX: begin
				prod_q <= neg_q ? -raw : raw;
			end
			PH_RND: begin
				res_q <= (prod_q + half) >>> (cov_q ? COV_FRAC_BITS : ANGLE_FRAC_BITS);
			end
			default: begin
			end
		endcase
	end

	assign sts.busy = (phase_q != PH_IDLE);
	assign sts.done = done_q;
	assign res      = res_q;

endmodule

// ----- design/kabf_div.sv -----
module kabf_div import kabf_pkg::*; #(
	parameter int COV_FRAC_BITS = COV_FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  div_req_t                 req,
	output unit_sts_t                sts,
	output logic signed [DATA_W-1:0] res
);

	localparam int CW = $clog2(DIV_DW + 1);
	localparam int RW = DIV_SW + 1;

	phase_t                   phase_q, phase_nx;
	logic [DIV_DW-1:0]        dvd_q;
	logic [DIV_DW-1:0]        quo_q;
	logic [DIV_SW-1:0]        dmag_q;
	logic [RW-1:0]            rem_q;
	logic                     neg_q;
	logic [CW-1:0]            cnt_q;
	logic signed [DATA_W-1:0] res_q;
	logic                     done_q;
	logic [RW-1:0]            rsh;
	logic                     ge;
	logic [DIV_NW:0]          nmag;

	// Restoring division, one quotient bit per cycle.
	assign rsh  = {rem_q[RW-2:0], dvd_q[DIV_DW-1]};
	assign ge   = (rsh >= RW'(dmag_q));
	assign nmag = req.num[DIV_NW-1] ? (DIV_NW+1)'(-(DIV_NW+1)'(req.num))
		: (DIV_NW+1)'(req.num);

	// Phase sequencing.
	always_comb begin
		phase_nx = phase_q;
		case (phase_q)
			PH_IDLE: if (req.start) phase_nx = PH_RUN;
			PH_RUN:  if (cnt_q == CW'(DIV_DW - 1)) phase_nx = PH_FIX;
			PH_FIX:  phase_nx = PH_IDLE;
			default: phase_nx = PH_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			done_q  <= 1'b0;
		end else begin
			phase_q <= phase_nx;
			done_q  <= (phase_q == PH_FIX);
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (phase_q)
			PH_IDLE: begin
				if (req.start) begin
					dvd_q  <= DIV_DW'(nmag) << COV_FRAC_BITS;
					dmag_q <= req.den[DIV_SW-1] ? DIV_SW'(-req.den) : DIV_SW'(req.den);
					neg_q  <= req.num[DIV_NW-1] ^ req.den[DIV_SW-1];
					rem_q  <= '0;
					quo_q  <= '0;
					cnt_q  <= '0;
				end
			end
			PH_RUN: begin
				rem_q <= ge ? (rsh - RW'(dmag_q)) : rsh;
				quo_q <= {quo_q[DIV_DW-2:0], ge};
				dvd_q <= {dvd_q[DIV_DW-2:0], 1'b0};
				cnt_q <= cnt_q + CW'(1);
			end
			PH_FIX: begin
				// Apply the sign and saturate the quotient to 32 bits.
				if (!neg_q && quo_q > DIV_DW'(32'h7fffffff)) begin
					res_q <= 32'sh7fffffff;
				end else if (neg_q && quo_q > DIV_DW'(32'h80000000)) begin
					res_q <= 32'sh80000000;
				end else begin
					res_q <= neg_q ? -$signed(quo_q[DATA_W-1:0]) : $signed(quo_q[DATA_W-1:0]);
				end
			end
			default: begin
			end
		endcase
	end

	assign sts.busy = (phase_q != PH_IDLE);
	assign sts.done = done_q;
	assign res      = res_q;

endmodule

// ----- design/kalman_angle_bias_filter_top.sv -----
// Two-state Kalman filter for an angle and a gyro bias.
// Input stream: s_tdata carries measured_angle and measured_rate, s_tuser the
// command (0 update, 1 set the angle). Output stream: m_tdata carries angle_out
// and rate_out. The cfg channel writes time_step, the two process noise terms
// and the measurement noise; it is always ready. It must be written while idle;
// the block itself does not enforce this. An update runs twelve arithmetic
// steps, skipping both divisions when the innovation variance is zero, on one
// bit-serial multiplier and one bit-serial restoring divider. One request is
// worked on at a time. The result sits in an output register, so the next
// request is accepted while it waits. If the receiver stalls longer than the
// next request takes, the sequencer holds that result in its final state until
// the register frees up. Reset clears the angle, bias, rate and covariance and
// loads the default configuration; no clearing pass is needed.
`include "kalman_angle_bias_filter_top_macros.svh"
module kalman_angle_bias_filter_top import kabf_pkg::*; #(
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
	parameter int COV_FRAC_BITS   = COV_FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [55:0]           s_tdata,  // measured_angle[24:0], measured_rate[49:25]
	input  logic                  s_tuser,  // command
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [63:0]           m_tdata,  // angle_out[31:0], rate_out[63:32]
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	state_t                   state_q, state_nx;
	op_t                      op_q;
	logic [DT_W-1:0]          dt_q;
	logic [NOISE_W-1:0]       qa_q, qb_q, r_q;
	logic signed [DATA_W-1:0] angle_q, bias_q, rate_q;
	logic signed [DATA_W-1:0] p00_q, p01_q, p10_q, p11_q;
	logic signed [DATA_W-1:0] n00_q, n01_q, n10_q, n11_q;
	logic signed [DATA_W-1:0] k0_q, k1_q, y_q;
	logic signed [MUL_MW-1:0] b_q;
	logic signed [DIV_SW-1:0] s_q;
	logic signed [MEAS_W-1:0] meas_q, gyro_q;
	logic [63:0]              out_q;
	logic                     out_vld_q;
	mul_req_t                 mul_req;
	div_req_t                 div_req;
	unit_sts_t                mul_sts, div_sts;
	logic signed [MUL_PW-1:0] mr;
	logic signed [DATA_W-1:0] dq;
	logic signed [DIV_SW-1:0] s_sum;
	logic                     unit_done;
	logic                     out_free;
	logic                     in_acc;

	kabf_mul #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
		.COV_FRAC_BITS(COV_FRAC_BITS)
	) u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.req(mul_req),
		.sts(mul_sts),
		.res(mr)
	);

	kabf_div #(
		.COV_FRAC_BITS(COV_FRAC_BITS)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.sts(div_sts),
		.res(dq)
	);

	assign s_tready  = (state_q == ST_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_vld_q || m_tready;
	assign s_sum     = DIV_SW'(n00_q) + DIV_SW'({1'b0, r_q});
	assign unit_done = (op_q == OP_DIV_K0 || op_q == OP_DIV_K1) ? div_sts.done : mul_sts.done;
	assign m_tvalid  = out_vld_q;
	assign m_tdata   = out_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q <= DT_RST;
			qa_q <= QA_RST;
			qb_q <= QB_RST;
			r_q  <= R_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TIME_STEP: dt_q <= cfg_data[DT_W-1:0];
				REG_Q_ANGLE:   qa_q <= cfg_data[NOISE_W-1:0];
				REG_Q_BIAS:    qb_q <= cfg_data[NOISE_W-1:0];
				REG_R_MEAS:    r_q  <= cfg_data[NOISE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Next state.
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE:  if (in_acc) state_nx = s_tuser ? ST_DONE : ST_PREP;
			ST_PREP:  state_nx = ST_ISSUE;
			ST_ISSUE: state_nx = ST_WAIT;
			ST_WAIT:  if (unit_done) state_nx = (op_q == OP_K1_N01) ? ST_DONE : ST_ISSUE;
			ST_DONE:  if (out_free) state_nx = ST_IDLE;
			default:  state_nx = ST_IDLE;
		endcase
	end

	// Operand selection for the arithmetic units.
	always_comb begin
		mul_req       = '0;
		div_req       = '0;
		mul_req.start = (state_q == ST_ISSUE) && !(op_q == OP_DIV_K0 || op_q == OP_DIV_K1);
		div_req.start = (state_q == ST_ISSUE) && (op_q == OP_DIV_K0 || op_q == OP_DIV_K1);
		div_req.den   = s_q;
		div_req.num   = (op_q == OP_DIV_K1) ? n10_q : n00_q;
		case (op_q)
			OP_DT_RATE: begin
				mul_req.m = MUL_MW'(rate_q);
				mul_req.b = {16'd0, dt_q};
			end
			OP_DT_P11: begin
				mul_req.m = MUL_MW'(p11_q);
				mul_req.b = {16'd0, dt_q};
			end
			OP_DT_B: begin
				mul_req.m = b_q;
				mul_req.b = {16'd0, dt_q};
			end
			OP_DT_QB: begin
				mul_req.m = {9'd0, qb_q};
				mul_req.b = {16'd0, dt_q};
			end
			OP_K0_Y: begin
				mul_req.cov = 1'b1;
				mul_req.m   = MUL_MW'(y_q);
				mul_req.b   = MUL_BW'(k0_q);
			end
			OP_K1_Y: begin
				mul_req.cov = 1'b1;
				mul_req.m   = MUL_MW'(y_q);
				mul_req.b   = MUL_BW'(k1_q);
			end
			OP_K0_N00: begin
				mul_req.cov = 1'b1;
				mul_req.m   = MUL_MW'(n00_q);
				mul_req.b   = MUL_BW'(k0_q);
			end
			OP_K0_N01: begin
				mul_req.cov = 1'b1;
				mul_req.m   = MUL_MW'(n01_q);
				mul_req.b   = MUL_BW'(k0_q);
			end
			OP_K1_N00: begin
				mul_req.cov = 1'b1;
				mul_req.m   = MUL_MW'(n00_q);
				mul_req.b   = MUL_BW'(k1_q);
			end
			OP_K1_N01: begin
				mul_req.cov = 1'b1;
				mul_req.m   = MUL_MW'(n01_q);
				mul_req.b   = MUL_BW'(k1_q);
			end
			default: begin
			end
		endcase
	end

	// Control state and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			op_q      <= OP_DT_RATE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_PREP) begin
				op_q <= OP_DT_RATE;
			end else if (state_q == ST_WAIT && unit_done) begin
				if (op_q == OP_DT_QB && s_sum == '0) begin
					op_q <= OP_K0_Y;
				end else if (op_q != OP_K1_N01) begin
					op_q <= op_t'(op_q + 4'd1);
				end
			end
			if (state_q == ST_DONE && out_free) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Filter state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q <= '0;
			bias_q  <= '0;
			rate_q  <= '0;
			p00_q   <= '0;
			p01_q   <= '0;
			p10_q   <= '0;
			p11_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc && s_tuser) begin
						angle_q <= DATA_W'($signed(s_tdata[MEAS_W-1:0]));
					end
				end
				ST_PREP: begin
					rate_q <= sat32(WIDE_W'(gyro_q) - WIDE_W'(bias_q));
				end
				ST_WAIT: begin
					if (unit_done) begin
						case (op_q)
							OP_DT_RATE: angle_q <= sat32(WIDE_W'(angle_q) + WIDE_W'(mr));
							OP_K0_Y:    angle_q <= sat32(WIDE_W'(angle_q) + WIDE_W'(mr));
							OP_K1_Y:    bias_q  <= sat32(WIDE_W'(bias_q) + WIDE_W'(mr));
							OP_K0_N00:  p00_q   <= sat32(WIDE_W'(n00_q) - WIDE_W'(mr));
							OP_K0_N01:  p01_q   <= sat32(WIDE_W'(n01_q) - WIDE_W'(mr));
							OP_K1_N00:  p10_q   <= sat32(WIDE_W'(n10_q) - WIDE_W'(mr));
							OP_K1_N01:  p11_q   <= sat32(WIDE_W'(n11_q) - WIDE_W'(mr));
							default: begin
							end
						endcase
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Working registers of one update.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			meas_q <= $signed(s_tdata[MEAS_W-1:0]);
			gyro_q <= $signed(s_tdata[2*MEAS_W-1:MEAS_W]);
		end
		if (state_q == ST_DONE && out_free) begin
			out_q <= {rate_q, angle_q};
		end
		if (state_q == ST_WAIT && unit_done) begin
			case (op_q)
				OP_DT_P11: begin
					n01_q <= sat32(WIDE_W'(p01_q) - WIDE_W'(mr));
					n10_q <= sat32(WIDE_W'(p10_q) - WIDE_W'(mr));
					b_q   <= MUL_MW'(WIDE_W'(mr) - WIDE_W'(p01_q) - WIDE_W'(p10_q)
						+ WIDE_W'({1'b0, qa_q}));
				end
				OP_DT_B: begin
					n00_q <= sat32(WIDE_W'(p00_q) + WIDE_W'(mr));
				end
				OP_DT_QB: begin
					n11_q <= sat32(WIDE_W'(p11_q) + WIDE_W'(mr));
					s_q   <= s_sum;
					y_q   <= sat32(WIDE_W'(meas_q) - WIDE_W'(angle_q));
					// A zero innovation variance leaves both gains at zero.
					if (s_sum == '0) begin
						k0_q <= '0;
						k1_q <= '0;
					end
				end
				OP_DIV_K0: k0_q <= dq;
				OP_DIV_K1: k1_q <= dq;
				default: begin
				end
			endcase
		end
	end

	`KABF_ASSERT_IMP(a_units_excl, 1'b1, !(mul_sts.busy && div_sts.busy), "both units busy")
	`KABF_ASSERT_NXT(a_accept_starts, in_acc, state_q == ST_PREP || state_q == ST_DONE, "request not started")
	`KABF_ASSERT_NXT(a_done_holds, state_q == ST_DONE && out_vld_q && !m_tready, state_q == ST_DONE && out_vld_q, "result dropped while stalled")
	`KABF_ASSERT_IMP(a_wait_busy, state_q == ST_WAIT && !unit_done, mul_sts.busy || div_sts.busy, "waiting on an idle unit")

endmodule
